[hw/rtl/act_pkg.sv]
// Package for the animation crossfade tracker: sizes, opcodes, controller
// states and the controller/datapath command and status structs. No dependencies.
package act_pkg;

  localparam int NUM_STATES = 16;
  localparam int MAX_TRACKS = 8;
  localparam int SID_W      = 4;
  localparam int TRK_W      = 3;
  localparam int CNT_W      = 4;

  localparam logic [16:0] WEIGHT_ONE     = 17'd32768;
  localparam logic [27:0] RATE_NEAR_ZERO = 28'd4096000;
  localparam logic [27:0] RATE_MAX       = 28'd134217727;

  typedef enum logic [1:0] {
    OP_DEFINE = 2'd0,
    OP_PLAY   = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PLAY_SCAN,
    ST_PLAY_DIV,
    ST_PLAY_APPLY,
    ST_TICK_MUL1,
    ST_TICK_MUL2,
    ST_TICK_WB,
    ST_COMPACT,
    ST_REPORT
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic             latch_item;
    logic             do_define;
    logic             scan_step;
    logic             play_decide;
    logic             div_start;
    logic             play_apply;
    logic             tick_mul1;
    logic             tick_mul2;
    logic             tick_wb;
    logic             compact_step;
    logic             rpt_emit;
    logic [TRK_W-1:0] idx;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic             play_go;
    logic             div_done;
    logic [CNT_W-1:0] count;
  } dp_sts_t;

endpackage

[hw/rtl/act_div.sv]
// Radix-2 restoring divider computing 2^28 / fade_time, one quotient bit a cycle.
// Depends on act_pkg.
module act_div
  import act_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [28:0] quot_o
);

  logic [5:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic [32:0] rem_q, rem_d;
  logic [28:0] quo_q, quo_d;
  logic [31:0] dvs_q, dvs_d;
  logic [32:0] trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  // Dividend bit 28 is the only one set; shift it in at the first step.
  always_comb begin
    run_d = run_q;
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    trial = {rem_q[31:0], (cnt_q == 6'd0)} - {1'b0, dvs_q};
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      quo_d = '0;
      dvs_d = divisor_i;
    end else if (run_q) begin
      if (!trial[32]) begin
        rem_d = trial;
        quo_d = {quo_q[27:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], (cnt_q == 6'd0)};
        quo_d = {quo_q[27:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd28) run_d = 1'b0;
    end
  end

  assign done_o = run_q && (cnt_q == 6'd28);
  assign quot_o = quo_d;

endmodule

[hw/rtl/act_datapath.sv]
// Datapath: state table, track list, time/weight arithmetic, result registers.
// Depends on act_pkg and act_div.
module act_datapath
  import act_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_sts_t           sts_o,
  input  logic [15:0]       speed_scale_i,
  input  logic [SID_W-1:0]  state_id_i,
  input  logic              clip_present_i,
  input  logic              loop_flag_i,
  input  logic signed [15:0] speed_i,
  input  logic [30:0]       clip_duration_i,
  input  logic [31:0]       fade_time_i,
  input  logic              restart_i,
  input  logic [15:0]       dt_i,
  output logic              res_strobe_o,
  output logic              track_valid_o,
  output logic [SID_W-1:0]  track_state_o,
  output logic signed [31:0] track_time_o,
  output logic [15:0]       track_weight_o,
  output logic              is_current_o,
  output logic              table_full_o,
  output logic              last_o
);

  // state table
  logic [NUM_STATES-1:0] st_def_q, st_loop_q;
  logic signed [15:0]    st_speed_q [NUM_STATES];
  logic [30:0]           st_dur_q   [NUM_STATES];

  // track list
  logic [SID_W-1:0]   tr_sid_q  [MAX_TRACKS];
  logic signed [31:0] tr_time_q [MAX_TRACKS];
  logic [15:0]        tr_w_q    [MAX_TRACKS];
  logic signed [27:0] tr_rate_q [MAX_TRACKS];
  logic [CNT_W-1:0]   count_q;
  logic [SID_W-1:0]   cur_sid_q;
  logic               cur_vld_q;
  logic               refused_q;

  // latched item
  logic [SID_W-1:0] sid_q;
  logic [31:0]      fade_q;
  logic             restart_q;
  logic [15:0]      dt_q;

  // play scan
  logic             hit_q;
  logic [TRK_W-1:0] hit_idx_q;
  logic             go_q;
  logic [27:0]      rate_q;

  // tick pipeline
  logic signed [32:0] p1_q;
  logic [43:0]        wstep_q;
  logic signed [49:0] p2_q;

  // compaction
  logic [CNT_W-1:0] wr_q;

  // divider
  logic        div_done;
  logic [28:0] div_quot;

  act_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .divisor_i (fade_q),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  logic [TRK_W-1:0] ix;
  logic [SID_W-1:0] tsid;
  assign ix   = cmd_i.idx;
  assign tsid = tr_sid_q[ix];

  // weight step magnitude >> 13 and time step math
  logic [27:0]        rate_abs;
  logic [30:0]        wmag;
  logic signed [18:0] wnew;
  logic [49:0]        p2_abs;
  logic signed [34:0] tstep;
  logic signed [34:0] tsum;
  logic signed [31:0] tsat;
  logic signed [31:0] tfin;
  logic [27:0]        rate_sel;

  always_comb begin
    rate_abs = tr_rate_q[ix][27] ? 28'(-tr_rate_q[ix]) : 28'(tr_rate_q[ix]);
    wmag     = 31'(wstep_q >> 13);
    if (tr_rate_q[ix][27]) wnew = 19'sd0 + $signed({3'b0, tr_w_q[ix]}) - $signed({1'b0, wmag[17:0]});
    else                   wnew = 19'sd0 + $signed({3'b0, tr_w_q[ix]}) + $signed({1'b0, wmag[17:0]});
    if (tr_rate_q[ix][27] && wmag > 31'd65535) wnew = -19'sd1;
    if (!tr_rate_q[ix][27] && wmag > 31'd65535) wnew = 19'sd65536;
    p2_abs = p2_q[49] ? 50'(-p2_q) : 50'(p2_q);
    tstep  = p2_q[49] ? -$signed({1'b0, p2_abs[49:16]}) : $signed({1'b0, p2_abs[49:16]});
    tsum   = 35'(tr_time_q[ix]) + tstep;
    if (tsum > 35'sd2147483647)       tsat = 32'sh7fffffff;
    else if (tsum < -35'sd2147483648) tsat = 32'sh80000000;
    else                              tsat = tsum[31:0];
    tfin = tsat;
    if (!st_loop_q[tsid] && (tsat > $signed({1'b0, st_dur_q[tsid]})))
      tfin = $signed({1'b0, st_dur_q[tsid]});
    if (fade_q < 32'd7)                 rate_sel = RATE_NEAR_ZERO;
    else if (div_quot == 29'd0)         rate_sel = 28'd1;
    else if (div_quot > {1'b0, RATE_MAX}) rate_sel = RATE_MAX;
    else                                rate_sel = div_quot[27:0];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_def_q  <= '0;
      st_loop_q <= '0;
      count_q   <= '0;
      cur_sid_q <= '0;
      cur_vld_q <= 1'b0;
      refused_q <= 1'b0;
      res_strobe_o <= 1'b0;
    end else begin
      res_strobe_o <= cmd_i.rpt_emit;
      if (cmd_i.do_define && clip_present_i) begin
        st_def_q[state_id_i]  <= 1'b1;
        st_loop_q[state_id_i] <= loop_flag_i;
      end
      if (cmd_i.play_decide) begin
        if (!st_def_q[sid_q] || (cur_vld_q && cur_sid_q == sid_q && !restart_q))
          refused_q <= 1'b0;
        else if (!hit_q && count_q == CNT_W'(MAX_TRACKS))
          refused_q <= 1'b1;
        else
          refused_q <= 1'b0;
      end
      if (cmd_i.play_apply && go_q) begin
        cur_sid_q <= sid_q;
        cur_vld_q <= 1'b1;
        if (!hit_q) count_q <= count_q + 1'b1;
      end
      if (cmd_i.compact_step && (32'(ix) + 1 == 32'(count_q))) begin
        count_q <= (tr_w_q[ix] == 16'd0 && tr_rate_q[ix][27]) ? wr_q : wr_q + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_define && clip_present_i) begin
      st_speed_q[state_id_i] <= speed_i;
      st_dur_q[state_id_i]   <= clip_duration_i;
    end
    if (cmd_i.latch_item) begin
      sid_q     <= state_id_i;
      fade_q    <= fade_time_i;
      restart_q <= restart_i;
      dt_q      <= dt_i;
      hit_q     <= 1'b0;
      hit_idx_q <= '0;
      wr_q      <= '0;
    end
    if (cmd_i.scan_step && !restart_q && !hit_q && tsid == sid_q) begin
      hit_q     <= 1'b1;
      hit_idx_q <= ix;
    end
    if (cmd_i.play_decide)
      go_q <= st_def_q[sid_q] && !(cur_vld_q && cur_sid_q == sid_q && !restart_q)
              && (hit_q || count_q != CNT_W'(MAX_TRACKS));
    if (div_done) rate_q <= rate_sel;
    if (cmd_i.play_apply && go_q) begin
      // revived or appended track fades in, all others fade out
      for (int i = 0; i < MAX_TRACKS; i++) begin
        if (hit_q ? (TRK_W'(i) == hit_idx_q) : (CNT_W'(i) == count_q))
          tr_rate_q[i] <= $signed(rate_q);
        else
          tr_rate_q[i] <= -$signed(rate_q);
      end
      if (!hit_q) begin
        tr_sid_q[count_q[TRK_W-1:0]]  <= sid_q;
        tr_time_q[count_q[TRK_W-1:0]] <= '0;
        tr_w_q[count_q[TRK_W-1:0]]    <= (count_q == '0) ? 16'd32768 : 16'd0;
      end
    end
    if (cmd_i.tick_mul1) begin
      p1_q    <= $signed({1'b0, dt_q}) * st_speed_q[tsid];
      wstep_q <= rate_abs * dt_q;
    end
    if (cmd_i.tick_mul2) p2_q <= p1_q * $signed(speed_scale_i);
    if (cmd_i.tick_wb) begin
      tr_time_q[ix] <= tfin;
      if (wnew < 0)                   tr_w_q[ix] <= 16'd0;
      else if (wnew > 19'sd32768)     tr_w_q[ix] <= 16'd32768;
      else                            tr_w_q[ix] <= wnew[15:0];
    end
    if (cmd_i.compact_step && !(tr_w_q[ix] == 16'd0 && tr_rate_q[ix][27])) begin
      tr_sid_q[wr_q[TRK_W-1:0]]  <= tr_sid_q[ix];
      tr_time_q[wr_q[TRK_W-1:0]] <= tr_time_q[ix];
      tr_w_q[wr_q[TRK_W-1:0]]    <= tr_w_q[ix];
      tr_rate_q[wr_q[TRK_W-1:0]] <= tr_rate_q[ix];
      wr_q <= wr_q + 1'b1;
    end
    if (cmd_i.rpt_emit) begin
      track_valid_o  <= (count_q != '0);
      track_state_o  <= (count_q != '0) ? tsid : '0;
      track_time_o   <= (count_q != '0) ? tr_time_q[ix] : '0;
      track_weight_o <= (count_q != '0) ? tr_w_q[ix] : '0;
      is_current_o   <= (count_q != '0) && cur_vld_q && (tsid == cur_sid_q);
      table_full_o   <= refused_q;
      last_o         <= (count_q == '0) || (32'(ix) + 1 == 32'(count_q));
    end
  end

  assign sts_o.play_go  = go_q;
  assign sts_o.div_done = div_done;
  assign sts_o.count    = count_q;

  // Track count never exceeds the table size.
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_TRACKS)) else $error("track count overflow");
  // A refused play never changes the track count.
  a_refuse_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.play_apply && !go_q |=> $stable(count_q)) else $error("refused play changed tracks");
  // An emitted result is strobed in the cycle after.
  a_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rpt_emit |=> res_strobe_o) else $error("missing result strobe");

endmodule

[hw/rtl/act_ctrl.sv]
// Controller state machine sequencing define, play, tick, compaction and report.
// Depends on act_pkg.
module act_ctrl
  import act_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] opcode_i,
  input  dp_sts_t    sts_i,
  output dp_cmd_t    cmd_o,
  output logic       busy_o
);

  ctrl_state_e state_q, state_d;
  logic [TRK_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] cnt1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign cnt1 = CNT_W'(idx_q) + 1'b1;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    cmd_o.idx = idx_q;
    busy_o  = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.latch_item = 1'b1;
          idx_d = '0;
          case (opcode_e'(opcode_i))
            OP_DEFINE: begin
              cmd_o.do_define = 1'b1;
              state_d = ST_REPORT;
            end
            OP_PLAY: state_d = (sts_i.count == '0) ? ST_PLAY_DIV : ST_PLAY_SCAN;
            OP_TICK: state_d = (sts_i.count == '0) ? ST_REPORT : ST_TICK_MUL1;
            default: state_d = ST_REPORT;
          endcase
        end
      end
      ST_PLAY_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (cnt1 == sts_i.count) begin
          idx_d = '0;
          state_d = ST_PLAY_DIV;
        end else idx_d = idx_q + 1'b1;
      end
      ST_PLAY_DIV: begin
        // first cycle decides and starts the divider; wait for done
        if (idx_q == '0) begin
          cmd_o.play_decide = 1'b1;
          cmd_o.div_start = 1'b1;
          idx_d = TRK_W'(1);
        end else if (sts_i.div_done) begin
          idx_d = '0;
          state_d = ST_PLAY_APPLY;
        end
      end
      ST_PLAY_APPLY: begin
        cmd_o.play_apply = 1'b1;
        state_d = ST_REPORT;
      end
      ST_TICK_MUL1: begin
        cmd_o.tick_mul1 = 1'b1;
        state_d = ST_TICK_MUL2;
      end
      ST_TICK_MUL2: begin
        cmd_o.tick_mul2 = 1'b1;
        state_d = ST_TICK_WB;
      end
      ST_TICK_WB: begin
        cmd_o.tick_wb = 1'b1;
        if (cnt1 == sts_i.count) begin
          idx_d = '0;
          state_d = ST_COMPACT;
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = ST_TICK_MUL1;
        end
      end
      ST_COMPACT: begin
        cmd_o.compact_step = 1'b1;
        if (cnt1 == sts_i.count) begin
          idx_d = '0;
          state_d = ST_REPORT;
        end else idx_d = idx_q + 1'b1;
      end
      ST_REPORT: begin
        cmd_o.rpt_emit = 1'b1;
        if (sts_i.count == '0 || cnt1 == sts_i.count) begin
          idx_d = '0;
          state_d = ST_IDLE;
        end else idx_d = idx_q + 1'b1;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Report never starts past the live tracks.
  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REPORT && sts_i.count != '0) |-> CNT_W'(idx_q) < sts_i.count)
    else $error("report index beyond track count");
  // Busy is low only in idle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o == (state_q != ST_IDLE)) else $error("busy mismatch");
  // A start taken leaves idle.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && state_q == ST_IDLE) |=> state_q != ST_IDLE) else $error("start lost");

endmodule

[hw/rtl/animation_crossfade_tracker_top.sv]
// Animation crossfade tracker: one item per start while busy is low. A define
// is accepted and then reports; a play is accepted, scans the live tracks,
// starts the divider, waits for the 29 quotient bits of 2^28/fade_time and
// applies; a tick runs multiply, multiply and write-back for each track, then
// a compaction pass over the tracks. Every item then reports one result per live
// track (or one empty result), one per cycle, each held on the result ports for
// a single cycle with res_valid_o; the receiver cannot stall.
// Depends on act_pkg, act_ctrl, act_datapath, act_div.
module animation_crossfade_tracker_top
  import act_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        opcode_i,
  input  logic [3:0]        state_id_i,
  input  logic              clip_present_i,
  input  logic              loop_flag_i,
  input  logic signed [15:0] speed_i,
  input  logic [30:0]       clip_duration_i,
  input  logic [31:0]       fade_time_i,
  input  logic              restart_i,
  input  logic [15:0]       dt_i,
  output logic              res_valid_o,
  output logic              track_valid_o,
  output logic [3:0]        track_state_o,
  output logic signed [31:0] track_time_o,
  output logic [15:0]       track_weight_o,
  output logic              is_current_o,
  output logic              table_full_o,
  output logic              last_o
);

  logic [15:0] scale_q;
  dp_cmd_t     cmd;
  dp_sts_t     sts;

  // configuration register transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) scale_q <= 16'd256;
    else if (psel && penable && pwrite && paddr == 2'd0) scale_q <= pwdata[15:0];
  end

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {{16{scale_q[15]}}, scale_q} : 32'd0;

  act_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (opcode_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  act_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .speed_scale_i   (scale_q),
    .state_id_i      (state_id_i),
    .clip_present_i  (clip_present_i),
    .loop_flag_i     (loop_flag_i),
    .speed_i         (speed_i),
    .clip_duration_i (clip_duration_i),
    .fade_time_i     (fade_time_i),
    .restart_i       (restart_i),
    .dt_i            (dt_i),
    .res_strobe_o    (res_valid_o),
    .track_valid_o   (track_valid_o),
    .track_state_o   (track_state_o),
    .track_time_o    (track_time_o),
    .track_weight_o  (track_weight_o),
    .is_current_o    (is_current_o),
    .table_full_o    (table_full_o),
    .last_o          (last_o)
  );

endmodule

[sim/crossfade_checker.sv]
// Crossfade tracker checker: watches the item, result and APB channels, keeps a
// software copy of the state and track tables, and compares every result transfer.
// Depends on act_pkg for the opcode enum, table sizes and rate limits.
module crossfade_checker
  import act_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [1:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  opcode_i,
  input  logic [3:0]  state_id_i,
  input  logic        clip_present_i,
  input  logic        loop_flag_i,
  input  logic [15:0] speed_i,
  input  logic [30:0] clip_duration_i,
  input  logic [31:0] fade_time_i,
  input  logic        restart_i,
  input  logic [15:0] dt_i,
  input  logic        res_valid_i,
  input  logic        track_valid_i,
  input  logic [3:0]  track_state_i,
  input  logic [31:0] track_time_i,
  input  logic [15:0] track_weight_i,
  input  logic        is_current_i,
  input  logic        table_full_i,
  input  logic        last_i,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] SCALE_ADDR = 2'd0;

  typedef struct packed {
    logic        valid;
    logic [3:0]  sid;
    logic [31:0] play_time;
    logic [15:0] weight;
    logic        cur;
    logic        full;
    logic        last;
  } track_report_t;

  // state table
  logic                clip_defined [NUM_STATES];
  logic                clip_loops [NUM_STATES];
  logic signed [15:0]  clip_speed [NUM_STATES];
  logic [30:0]         clip_len [NUM_STATES];
  // track list
  logic [3:0]          trk_sid [MAX_TRACKS];
  longint              trk_time [MAX_TRACKS];
  longint              trk_weight [MAX_TRACKS];
  longint              trk_rate [MAX_TRACKS];
  int                  trk_count;
  logic [3:0]          cur_sid;
  logic                cur_valid;
  logic                refused;
  logic signed [15:0]  scale;

  track_report_t report_q[$];
  int                    errors = 0;
  int                    pending = 0;

  assign errors_o  = errors;
  assign pending_o = pending;

  function automatic longint shift_toward_zero(longint v, int sh);
    longint m;
    m = (v < 0) ? -v : v;
    m = m >>> sh;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint rate_for_fade(logic [31:0] fade);
    longint r;
    if (fade < 32'd7) return longint'(RATE_NEAR_ZERO);
    r = (longint'(1) << 28) / longint'(fade);
    if (r < 1) r = 1;
    if (r > longint'(RATE_MAX)) r = longint'(RATE_MAX);
    return r;
  endfunction

  task automatic apply_play(logic [3:0] sid, logic [31:0] fade, logic rst);
    int     hit;
    longint r;
    hit = MAX_TRACKS;
    if (!clip_defined[sid]) begin
      refused = 1'b0;
      return;
    end
    if (cur_valid && cur_sid == sid && !rst) begin
      refused = 1'b0;
      return;
    end
    if (!rst) begin
      for (int i = 0; i < trk_count; i++) begin
        if (trk_sid[i] == sid) begin
          hit = i;
          break;
        end
      end
    end
    if (hit == MAX_TRACKS && trk_count >= MAX_TRACKS) begin
      refused = 1'b1;
      return;
    end
    refused = 1'b0;
    r = rate_for_fade(fade);
    for (int i = 0; i < trk_count; i++) trk_rate[i] = -r;
    if (hit < MAX_TRACKS) begin
      trk_rate[hit] = r;
    end else begin
      trk_sid[trk_count]    = sid;
      trk_time[trk_count]   = 0;
      trk_weight[trk_count] = (trk_count == 0) ? 32768 : 0;
      trk_rate[trk_count]   = r;
      trk_count++;
    end
    cur_sid   = sid;
    cur_valid = 1'b1;
  endtask

  task automatic apply_tick(logic [15:0] dt);
    int     k;
    longint t;
    longint w;
    k = 0;
    for (int i = 0; i < trk_count; i++) begin
      t = trk_time[i] + shift_toward_zero(longint'(dt) * longint'(clip_speed[trk_sid[i]])
                                          * longint'(scale), 16);
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      if (!clip_loops[trk_sid[i]] && t > longint'(clip_len[trk_sid[i]]))
        t = longint'(clip_len[trk_sid[i]]);
      trk_time[i] = t;
      w = trk_weight[i] + shift_toward_zero(trk_rate[i] * longint'(dt), 13);
      if (w < 0) w = 0;
      if (w > 32768) w = 32768;
      trk_weight[i] = w;
    end
    // drop faded-out tracks, keep list order
    for (int i = 0; i < trk_count; i++) begin
      if (!(trk_weight[i] <= 0 && trk_rate[i] < 0)) begin
        trk_sid[k]    = trk_sid[i];
        trk_time[k]   = trk_time[i];
        trk_weight[k] = trk_weight[i];
        trk_rate[k]   = trk_rate[i];
        k++;
      end
    end
    trk_count = k;
  endtask

  task automatic queue_report();
    track_report_t e;
    if (trk_count == 0) begin
      e = '0;
      e.full = refused;
      e.last = 1'b1;
      report_q = {report_q, e};
      return;
    end
    for (int i = 0; i < trk_count; i++) begin
      e.valid     = 1'b1;
      e.sid       = trk_sid[i];
      e.play_time = trk_time[i][31:0];
      e.weight    = trk_weight[i][15:0];
      e.cur       = cur_valid && trk_sid[i] == cur_sid;
      e.full      = refused;
      e.last      = (i == trk_count - 1);
      report_q = {report_q, e};
    end
  endtask

  task automatic compare_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    track_report_t e;
    if (!rst_ni) begin
      trk_count = 0;
      cur_sid   = '0;
      cur_valid = 1'b0;
      refused   = 1'b0;
      scale     = 16'sd256;
      for (int i = 0; i < NUM_STATES; i++) begin
        clip_defined[i] = 1'b0;
        clip_loops[i]   = 1'b0;
      end
      report_q.delete();
    end else begin
      // result transfer
      if (res_valid_i) begin
        if (report_q.size() == 0) begin
          $error("result transfer with no expectation waiting");
          errors++;
        end else begin
          e = report_q.pop_front();
          compare_field("track_valid", longint'(e.valid), longint'(track_valid_i));
          compare_field("track_state", longint'(e.sid), longint'(track_state_i));
          compare_field("track_time", longint'($signed(e.play_time)),
                        longint'($signed(track_time_i)));
          compare_field("track_weight", longint'(e.weight), longint'(track_weight_i));
          compare_field("is_current", longint'(e.cur), longint'(is_current_i));
          compare_field("table_full", longint'(e.full), longint'(table_full_i));
          compare_field("last", longint'(e.last), longint'(last_i));
        end
      end
      // register write
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == SCALE_ADDR)
        scale = pwdata_i[15:0];
      // item transfer
      if (start_i && !busy_i) begin
        case (opcode_e'(opcode_i))
          OP_DEFINE: begin
            if (clip_present_i) begin
              clip_defined[state_id_i] = 1'b1;
              clip_loops[state_id_i]   = loop_flag_i;
              clip_speed[state_id_i]   = speed_i;
              clip_len[state_id_i]     = clip_duration_i;
            end
          end
          OP_PLAY: apply_play(state_id_i, fade_time_i, restart_i);
          OP_TICK: apply_tick(dt_i);
          default: ;
        endcase
        queue_report();
      end
    end
    pending = report_q.size();
  end

endmodule

[sim/tb_top.sv]
// Testbench top for the animation crossfade tracker: drives items and the
// speed_scale register, and gives the verdict. Depends on act_pkg, the RTL
// and crossfade_checker.
module tb_top
  import act_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] SCALE_ADDR = 2'd0;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [1:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        start, busy;
  logic [1:0]  opcode;
  logic [3:0]  state_id;
  logic        clip_present, loop_flag, restart;
  logic [15:0] speed, dt;
  logic [30:0] clip_duration;
  logic [31:0] fade_time;
  logic        res_valid, track_valid, is_current, table_full, last;
  logic [3:0]  track_state;
  logic [31:0] track_time;
  logic [15:0] track_weight;
  int          errors, pending;
  int          idle_pct;

  animation_crossfade_tracker_top DUT (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy,
    .opcode_i(opcode), .state_id_i(state_id), .clip_present_i(clip_present),
    .loop_flag_i(loop_flag), .speed_i(speed), .clip_duration_i(clip_duration),
    .fade_time_i(fade_time), .restart_i(restart), .dt_i(dt),
    .res_valid_o(res_valid), .track_valid_o(track_valid), .track_state_o(track_state),
    .track_time_o(track_time), .track_weight_o(track_weight), .is_current_o(is_current),
    .table_full_o(table_full), .last_o(last)
  );

  crossfade_checker u_checker (
    .clk_i, .rst_ni,
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .start_i(start), .busy_i(busy),
    .opcode_i(opcode), .state_id_i(state_id), .clip_present_i(clip_present),
    .loop_flag_i(loop_flag), .speed_i(speed), .clip_duration_i(clip_duration),
    .fade_time_i(fade_time), .restart_i(restart), .dt_i(dt),
    .res_valid_i(res_valid), .track_valid_i(track_valid), .track_state_i(track_state),
    .track_time_i(track_time), .track_weight_i(track_weight),
    .is_current_i(is_current), .table_full_i(table_full), .last_i(last),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5ms;
    $display("tb_top NOT OK");
    $finish;
  end

  // one item transfer; idles first at the phase's rate
  task automatic send_item(opcode_e op, logic [3:0] sid, logic cp, logic lp,
                           logic [15:0] spd, logic [30:0] dur, logic [31:0] fade,
                           logic rs, logic [15:0] d);
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat ($urandom_range(4)) @(negedge clk_i);
    end else begin
      @(negedge clk_i);
    end
    start = 1'b1;
    opcode = op; state_id = sid; clip_present = cp; loop_flag = lp;
    speed = spd; clip_duration = dur; fade_time = fade; restart = rs; dt = d;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_scale(logic [15:0] v);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; paddr = SCALE_ADDR; pwdata = {{16{v[15]}}, v};
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic define_clip(logic [3:0] sid, logic lp, logic [15:0] spd, logic [30:0] dur);
    send_item(OP_DEFINE, sid, 1'b1, lp, spd, dur, $urandom, 1'($urandom), 16'($urandom));
  endtask

  task automatic play_clip(logic [3:0] sid, logic [31:0] fade, logic rs);
    send_item(OP_PLAY, sid, 1'($urandom), 1'($urandom), 16'($urandom), 31'($urandom),
              fade, rs, 16'($urandom));
  endtask

  task automatic tick(logic [15:0] d);
    send_item(OP_TICK, 4'($urandom), 1'($urandom), 1'($urandom), 16'($urandom),
              31'($urandom), $urandom, 1'($urandom), d);
  endtask

  // random item, weighted toward meaningful define/play/tick sequences
  task automatic random_item();
    int          sel;
    logic [31:0] fade;
    logic [30:0] dur;
    sel = $urandom_range(99);
    case ($urandom_range(3))
      0: fade = $urandom_range(6);
      1: fade = $urandom_range(65536);
      2: fade = $urandom_range(400000);
      default: fade = $urandom;
    endcase
    dur = ($urandom_range(1)) ? 31'($urandom_range(200000)) : 31'($urandom);
    if (sel < 20)
      define_clip(4'($urandom), 1'($urandom), 16'($urandom), dur);
    else if (sel < 23)
      send_item(OP_DEFINE, 4'($urandom), 1'b0, 1'($urandom), 16'($urandom),
                31'($urandom), $urandom, 1'($urandom), 16'($urandom));
    else if (sel < 55)
      play_clip(4'($urandom), fade, $urandom_range(7) == 0);
    else if (sel < 97)
      tick(($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4000)));
    else
      send_item(OP_NONE, 4'($urandom), 1'($urandom), 1'($urandom), 16'($urandom),
                31'($urandom), $urandom, 1'($urandom), 16'($urandom));
  endtask

  initial begin
    int          pct [4];
    logic [15:0] scales [4];
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    start = 1'b0; opcode = OP_NONE; state_id = '0; clip_present = 1'b0;
    loop_flag = 1'b0; speed = '0; clip_duration = '0; fade_time = '0;
    restart = 1'b0; dt = '0;
    idle_pct = 0;
    pct = '{0, 59, 0, 30};
    scales = '{16'h8000, 16'h7fff, 16'h0000, 16'h0100};
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty list, undefined play, ignored define, extremes, full table
    tick(16'hffff);
    play_clip(4'd3, 32'd100, 1'b0);
    send_item(OP_DEFINE, 4'd3, 1'b0, 1'b1, 16'h7fff, 31'h7fffffff, '0, 1'b0, '0);
    play_clip(4'd3, 32'd100, 1'b0);
    define_clip(4'd0, 1'b1, 16'h7fff, 31'h7fffffff);
    define_clip(4'd15, 1'b0, 16'h8000, 31'd0);
    define_clip(4'd3, 1'b0, 16'h0100, 31'h0003_0000);
    play_clip(4'd0, 32'd0, 1'b0);
    play_clip(4'd0, 32'd6, 1'b0);
    play_clip(4'd3, 32'd7, 1'b0);
    play_clip(4'd15, 32'hffffffff, 1'b0);
    play_clip(4'd0, 32'h0001_0000, 1'b0);
    tick(16'd0);
    tick(16'hffff);
    tick(16'hffff);
    send_item(OP_NONE, 4'hf, 1'b1, 1'b1, 16'hffff, 31'h7fffffff, 32'hffffffff, 1'b1,
              16'hffff);
    for (int i = 0; i < 9; i++) play_clip(4'd3, 32'hffffffff, 1'b1);
    play_clip(4'd0, 32'd7, 1'b0);
    tick(16'hffff);
    tick(16'hffff);
    drain();

    // random phases, one speed_scale setting each
    for (int ph = 0; ph < 4; ph++) begin
      write_scale(ph == 2 ? 16'($urandom) : scales[ph]);
      idle_pct = pct[ph];
      for (int n = 0; n < 85; n++) begin
        random_item();
        if (ph == 1 && n == 40) drain();
      end
      drain();
    end

    if (errors == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

[files.f]
hw/rtl/act_pkg.sv
hw/rtl/act_div.sv
hw/rtl/act_datapath.sv
hw/rtl/act_ctrl.sv
hw/rtl/animation_crossfade_tracker_top.sv
sim/crossfade_checker.sv
sim/tb_top.sv
